[rtl/rtp_playout_sequencer_unit_macros.svh]
// assertion macros used by the playout sequencer checker
`ifndef RTP_PLAYOUT_SEQUENCER_UNIT_MACROS_SVH
`define RTP_PLAYOUT_SEQUENCER_UNIT_MACROS_SVH

// same-cycle implication, reset masks the check
`define RPS_ASSERT_NOW(label, clk, rst, cond, conseq, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (conseq)) \
      else $error(msg);

// next-cycle implication, reset masks the check
`define RPS_ASSERT_NEXT(label, clk, rst, cond, conseq, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) \
      else $error(msg);

`endif

[rtl/rps_pkg.sv]
// types and codes shared by the playout sequencer files
`timescale 1ns / 1ps
`default_nettype none

package rps_pkg;

   // field widths
   localparam int OP_W     = 2;
   localparam int SEQ_W    = 16;
   localparam int TS_W     = 32;
   localparam int ACT_W    = 3;
   localparam int SLOT_W   = 6;
   localparam int FILL_W   = 7;
   localparam int COUNT_W  = 32;
   localparam int SPP_W    = 16;
   localparam int PRE_W    = 7;
   localparam int RCV_W    = 8;

   // configuration port
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 16;
   localparam logic [CSR_INDEX_W-1:0] REG_SPP     = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_PREFILL = 1'd1;

   // register reset values
   localparam logic [SPP_W-1:0] SPP_RESET     = 16'd160;
   localparam logic [PRE_W-1:0] PREFILL_RESET = 7'd8;

   // input operations
   localparam logic [OP_W-1:0] OP_HEADER  = 2'd0;
   localparam logic [OP_W-1:0] OP_TIMER   = 2'd1;
   localparam logic [OP_W-1:0] OP_PLAYOUT = 2'd2;

   // result actions
   localparam logic [ACT_W-1:0] ACT_PAYLOAD = 3'd0;
   localparam logic [ACT_W-1:0] ACT_SILENCE = 3'd1;
   localparam logic [ACT_W-1:0] ACT_PLAY    = 3'd2;
   localparam logic [ACT_W-1:0] ACT_OVERRUN = 3'd3;
   localparam logic [ACT_W-1:0] ACT_DISCARD = 3'd4;
   localparam logic [ACT_W-1:0] ACT_EMPTY   = 3'd5;

   // input word
   typedef struct packed {
      logic [OP_W-1:0]  operation;
      logic [SEQ_W-1:0] seq_number;
      logic [TS_W-1:0]  time_stamp;
   } req_word_type;

   // result word
   typedef struct packed {
      logic [ACT_W-1:0]   action;
      logic [SLOT_W-1:0]  slot_index;
      logic [FILL_W-1:0]  occupancy;
      logic [COUNT_W-1:0] lost_total;
      logic [COUNT_W-1:0] silence_total;
      logic               last;
   } rsp_word_type;

endpackage

`default_nettype wire

[rtl/rps_divider.sv]
// serial restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
`default_nettype none

module rps_divider (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [rps_pkg::TS_W-1:0]  dividend,
   input  logic [rps_pkg::SPP_W-1:0] divisor,
   output logic                      done,
   output logic [rps_pkg::TS_W-1:0]  quotient
);
   import rps_pkg::*;

   localparam int CNT_W = $clog2(TS_W);
   localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(TS_W - 1);

   logic               active_ff, active_in;
   logic               done_ff, done_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [SPP_W:0]     rem_ff, rem_in;
   logic [TS_W-1:0]    quo_ff, quo_in;
   logic [SPP_W-1:0]   den_ff, den_in;
   logic [SPP_W:0]     rem_shift;
   logic               fits;

   // trial subtract of the shifted remainder
   always_comb begin
      rem_shift = {rem_ff[SPP_W-1:0], quo_ff[TS_W-1]};
      fits      = rem_shift >= {1'b0, den_ff};
   end

   // step control
   always_comb begin
      active_in = active_ff;
      done_in   = 1'b0;
      cnt_in    = cnt_ff;
      rem_in    = rem_ff;
      quo_in    = quo_ff;
      den_in    = den_ff;
      if (start) begin
         active_in = 1'b1;
         cnt_in    = '0;
         rem_in    = '0;
         quo_in    = dividend;
         den_in    = divisor;
      end else if (active_ff) begin
         rem_in = fits ? (rem_shift - {1'b0, den_ff}) : rem_shift;
         quo_in = {quo_ff[TS_W-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == LAST_STEP) begin
            active_in = 1'b0;
            done_in   = 1'b1;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         done_ff   <= 1'b0;
         cnt_ff    <= '0;
      end else begin
         active_ff <= active_in;
         done_ff   <= done_in;
         cnt_ff    <= cnt_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire

[rtl/rtp_playout_sequencer_unit.sv]
// top level of the playout sequencer: ring bookkeeping and result sequencing
//
//   channel   ports                              handshake
//   -------   --------------------------------   ------------------------------
//   request   start, busy, req_word              taken when start && !busy
//   result    rsp_strobe, rsp_word               one word per strobe cycle
//   config    csr_write_en, csr_index, csr_data  written on csr_write_en
//
// timing: a word is decoded the cycle after it is taken; each result word
// leaves through an output register. a sequence gap of n, with a timestamp
// gap as well, adds n silence words, and a timestamp gap alone runs the divider
// and adds one silence word per packet of samples in the gap,
// silence capped at MAX_FILL words. reset is synchronous and restores the ring,
// counters and control registers, not the payload registers; the receiver cannot stall.
`timescale 1ns / 1ps
`default_nettype none

module rtp_playout_sequencer_unit #(
   parameter int RING_DEPTH = 64,
   parameter int MAX_FILL   = 63
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  rps_pkg::req_word_type          req_word,
   output logic                           rsp_strobe,
   output rps_pkg::rsp_word_type          rsp_word,
   input  logic                           csr_write_en,
   input  logic [rps_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [rps_pkg::CSR_DATA_W-1:0]  csr_data
);
   import rps_pkg::*;

   localparam int SW       = $clog2(RING_DEPTH);
   localparam int RING_CAP = (MAX_FILL < RING_DEPTH) ? MAX_FILL : RING_DEPTH;
   localparam int CW       = $clog2(MAX_FILL + 1);
   localparam logic [SW-1:0]     LAST_SLOT    = SW'(RING_DEPTH - 1);
   localparam logic [FILL_W-1:0] CAP_FILL     = FILL_W'(RING_CAP);
   localparam logic [CW-1:0]     FILL_MAX_CNT = CW'(MAX_FILL);
   localparam logic [SEQ_W-1:0]  GAP_LIMIT    = SEQ_W'(MAX_FILL);
   localparam logic [TS_W-1:0]   QUO_LIMIT    = TS_W'(MAX_FILL);

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_DECIDE = 5'b00010,
      ST_DIVIDE = 5'b00100,
      ST_FILL   = 5'b01000,
      ST_FINAL  = 5'b10000
   } state_type;

   state_type            state_ff, state_in;
   req_word_type         item_ff, item_in;
   logic                 playing_ff, playing_in;
   logic [RCV_W-1:0]     rcv_ff, rcv_in;
   logic [SPP_W-1:0]     spp_ff, spp_in;
   logic [PRE_W-1:0]     prefill_ff, prefill_in;
   logic [SW-1:0]        wr_ff, wr_in;
   logic [SW-1:0]        rd_ff, rd_in;
   logic [FILL_W-1:0]    fill_ff, fill_in;
   logic [SEQ_W-1:0]     exp_seq_ff, exp_seq_in;
   logic [TS_W-1:0]      exp_ts_ff, exp_ts_in;
   logic [COUNT_W-1:0]   lost_ff, lost_in;
   logic [COUNT_W-1:0]   sil_ff, sil_in;
   logic [CW-1:0]        cnt_ff, cnt_in;
   logic                 rsp_strobe_ff, rsp_strobe_in;
   rsp_word_type         rsp_word_ff, rsp_word_in;

   // ring write helper
   logic                 wb_silence;
   logic                 wb_full;
   logic [SW-1:0]        wb_wr_next;
   logic [SW-1:0]        wb_rd_next;
   logic [FILL_W-1:0]    wb_fill_next;
   logic [COUNT_W-1:0]   wb_sil_next;
   logic [ACT_W-1:0]     wb_action;

   // slot indexes widened to the result field
   logic [SW+SLOT_W-1:0] wr_ext;
   logic [SW+SLOT_W-1:0] rd_ext;
   logic [SLOT_W-1:0]    wr_slot;
   logic [SLOT_W-1:0]    rd_slot;

   // decode terms
   logic                 playing_now;
   logic                 seq_ok;
   logic                 ts_ok;
   logic [SEQ_W-1:0]     seq_gap;
   logic [SEQ_W-1:0]     gap_use;
   logic [TS_W-1:0]      ts_diff;

   // divider hookup
   logic                 div_start;
   logic                 div_done;
   logic [TS_W-1:0]      div_quo;

   rps_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (ts_diff),
      .divisor  (spp_ff),
      .done     (div_done),
      .quotient (div_quo)
   );

   always_comb begin
      wr_ext  = {{SLOT_W{1'b0}}, wr_ff};
      rd_ext  = {{SLOT_W{1'b0}}, rd_ff};
      wr_slot = wr_ext[SLOT_W-1:0];
      rd_slot = rd_ext[SLOT_W-1:0];
   end

   // one block into the ring, or an overrun reset when full
   always_comb begin
      wb_silence   = (state_ff == ST_FILL) || (state_ff == ST_DECIDE);
      wb_full      = fill_ff >= CAP_FILL;
      wb_wr_next   = (wb_full || (wr_ff == LAST_SLOT)) ? '0 : wr_ff + 1'b1;
      wb_rd_next   = wb_full ? '0 : rd_ff;
      wb_fill_next = wb_full ? '0 : fill_ff + 1'b1;
      wb_sil_next  = (!wb_full && wb_silence) ? sil_ff + 1'b1 : sil_ff;
      if (wb_full) begin
         wb_action = ACT_OVERRUN;
      end else if (wb_silence) begin
         wb_action = ACT_SILENCE;
      end else begin
         wb_action = ACT_PAYLOAD;
      end
   end

   // header compare terms
   always_comb begin
      playing_now = playing_ff || ({1'b0, prefill_ff} <= rcv_ff);
      seq_ok      = item_ff.seq_number == exp_seq_ff;
      ts_ok       = item_ff.time_stamp == exp_ts_ff;
      seq_gap     = item_ff.seq_number - exp_seq_ff;
      gap_use     = seq_gap[SEQ_W-1] ? '0 : seq_gap;
      ts_diff     = item_ff.time_stamp - exp_ts_ff;
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      item_in       = item_ff;
      playing_in    = playing_ff;
      rcv_in        = rcv_ff;
      wr_in         = wr_ff;
      rd_in         = rd_ff;
      fill_in       = fill_ff;
      exp_seq_in    = exp_seq_ff;
      exp_ts_in     = exp_ts_ff;
      lost_in       = lost_ff;
      sil_in        = sil_ff;
      cnt_in        = cnt_ff;
      div_start     = 1'b0;
      rsp_strobe_in = 1'b0;
      rsp_word_in   = rsp_word_ff;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               item_in  = req_word;
               state_in = ST_DECIDE;
            end
         end

         ST_DECIDE: begin
            playing_in = playing_now;
            // discard word unless a branch below overrides it
            rsp_word_in.action        = ACT_DISCARD;
            rsp_word_in.slot_index    = '0;
            rsp_word_in.occupancy     = fill_ff;
            rsp_word_in.lost_total    = lost_ff;
            rsp_word_in.silence_total = sil_ff;
            rsp_word_in.last          = 1'b1;
            if ((item_ff.operation == OP_HEADER) && !playing_now) begin
               state_in = ST_FINAL;
            end else if (item_ff.operation == OP_HEADER) begin
               if (seq_ok && ts_ok) begin
                  state_in = ST_FINAL;
               end else if (!seq_ok && !ts_ok) begin
                  // sequence gap: count the loss, queue silence words
                  lost_in  = lost_ff + {{(COUNT_W-SEQ_W){1'b0}}, gap_use};
                  cnt_in   = (gap_use > GAP_LIMIT) ? FILL_MAX_CNT : gap_use[CW-1:0];
                  state_in = (gap_use == '0) ? ST_FINAL : ST_FILL;
               end else if (seq_ok) begin
                  // timestamp gap: silence count comes from the divider
                  if (!ts_diff[TS_W-1] && (spp_ff != '0)) begin
                     div_start = 1'b1;
                     state_in  = ST_DIVIDE;
                  end else begin
                     state_in = ST_FINAL;
                  end
               end else begin
                  rsp_strobe_in = 1'b1;
                  state_in      = ST_IDLE;
               end
            end else if ((item_ff.operation == OP_TIMER) && playing_now) begin
               rsp_word_in.action        = wb_action;
               rsp_word_in.slot_index    = wr_slot;
               rsp_word_in.occupancy     = wb_fill_next;
               rsp_word_in.silence_total = wb_sil_next;
               wr_in   = wb_wr_next;
               rd_in   = wb_rd_next;
               fill_in = wb_fill_next;
               sil_in  = wb_sil_next;
               if (!wb_full) begin
                  exp_ts_in = exp_ts_ff + {{(TS_W-SPP_W){1'b0}}, spp_ff};
               end
               rsp_strobe_in = 1'b1;
               state_in      = ST_IDLE;
            end else if ((item_ff.operation == OP_PLAYOUT) && playing_now) begin
               rsp_word_in.slot_index = rd_slot;
               if (fill_ff != '0) begin
                  rsp_word_in.action    = ACT_PLAY;
                  rsp_word_in.occupancy = fill_ff - 1'b1;
                  rd_in   = (rd_ff == LAST_SLOT) ? '0 : rd_ff + 1'b1;
                  fill_in = fill_ff - 1'b1;
               end else begin
                  rsp_word_in.action = ACT_EMPTY;
               end
               rsp_strobe_in = 1'b1;
               state_in      = ST_IDLE;
            end else begin
               rsp_strobe_in = 1'b1;
               state_in      = ST_IDLE;
            end
         end

         ST_DIVIDE: begin
            if (div_done) begin
               cnt_in   = (div_quo > QUO_LIMIT) ? FILL_MAX_CNT : div_quo[CW-1:0];
               state_in = (div_quo == '0) ? ST_FINAL : ST_FILL;
            end
         end

         ST_FILL: begin
            // one silence word per cycle, or an overrun word when the ring is full
            rsp_word_in.action        = wb_action;
            rsp_word_in.slot_index    = wr_slot;
            rsp_word_in.occupancy     = wb_fill_next;
            rsp_word_in.lost_total    = lost_ff;
            rsp_word_in.silence_total = wb_sil_next;
            rsp_word_in.last          = 1'b0;
            rsp_strobe_in = 1'b1;
            wr_in   = wb_wr_next;
            rd_in   = wb_rd_next;
            fill_in = wb_fill_next;
            sil_in  = wb_sil_next;
            cnt_in  = cnt_ff - 1'b1;
            if (cnt_ff == CW'(1)) begin
               state_in = ST_FINAL;
            end
         end

         ST_FINAL: begin
            // store the payload and resync the expectations
            rsp_word_in.action        = wb_action;
            rsp_word_in.slot_index    = wr_slot;
            rsp_word_in.occupancy     = wb_fill_next;
            rsp_word_in.lost_total    = lost_ff;
            rsp_word_in.silence_total = wb_sil_next;
            rsp_word_in.last          = 1'b1;
            rsp_strobe_in = 1'b1;
            wr_in   = wb_wr_next;
            rd_in   = wb_rd_next;
            fill_in = wb_fill_next;
            sil_in  = wb_sil_next;
            if (!wb_full && (rcv_ff != '1)) begin
               rcv_in = rcv_ff + 1'b1;
            end
            exp_seq_in = item_ff.seq_number + 1'b1;
            exp_ts_in  = item_ff.time_stamp + {{(TS_W-SPP_W){1'b0}}, spp_ff};
            state_in   = ST_IDLE;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // configuration writes
   always_comb begin
      spp_in     = spp_ff;
      prefill_in = prefill_ff;
      if (csr_write_en) begin
         case (csr_index)
            REG_SPP:     spp_in     = csr_data[SPP_W-1:0];
            REG_PREFILL: prefill_in = csr_data[PRE_W-1:0];
            default: begin
               spp_in = spp_ff;
            end
         endcase
      end
   end

   // control and bookkeeping registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         playing_ff    <= 1'b0;
         rcv_ff        <= '0;
         spp_ff        <= SPP_RESET;
         prefill_ff    <= PREFILL_RESET;
         wr_ff         <= '0;
         rd_ff         <= '0;
         fill_ff       <= '0;
         exp_seq_ff    <= '0;
         exp_ts_ff     <= '0;
         lost_ff       <= '0;
         sil_ff        <= '0;
         cnt_ff        <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         playing_ff    <= playing_in;
         rcv_ff        <= rcv_in;
         spp_ff        <= spp_in;
         prefill_ff    <= prefill_in;
         wr_ff         <= wr_in;
         rd_ff         <= rd_in;
         fill_ff       <= fill_in;
         exp_seq_ff    <= exp_seq_in;
         exp_ts_ff     <= exp_ts_in;
         lost_ff       <= lost_in;
         sil_ff        <= sil_in;
         cnt_ff        <= cnt_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      rsp_word_ff <= rsp_word_in;
   end

   assign busy       = state_ff != ST_IDLE;
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_word   = rsp_word_ff;

endmodule

`default_nettype wire

[rtl/rps_checker.sv]
// port-level checks for the playout sequencer, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

`include "rtp_playout_sequencer_unit_macros.svh"

module rps_checker (
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  start,
   input wire logic                  busy,
   input wire logic                  rsp_strobe,
   input wire rps_pkg::rsp_word_type rsp_word
);
   import rps_pkg::*;

   // a taken word keeps the unit busy for its decode cycle
   `RPS_ASSERT_NEXT(a_take_busy, clock, reset, start && !busy, busy, "busy not raised after take")

   // words of one burst come back to back until the closing word
   `RPS_ASSERT_NEXT(a_burst_cont, clock, reset, rsp_strobe && !rsp_word.last, rsp_strobe, "gap inside result burst")

   // a burst can only be open while the unit is busy
   `RPS_ASSERT_NOW(a_burst_busy, clock, reset, rsp_strobe && !rsp_word.last, busy, "open burst while idle")

   // an overrun empties the ring
   `RPS_ASSERT_NOW(a_overrun_empty, clock, reset, rsp_strobe && (rsp_word.action == ACT_OVERRUN), rsp_word.occupancy == '0, "overrun with blocks left")

endmodule

bind rtp_playout_sequencer_unit rps_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .rsp_strobe (rsp_strobe),
   .rsp_word   (rsp_word)
);

`default_nettype wire
